>>> sv/circle_circle_intersection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circle intersection block
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_CIRCLE_INTERSECTION_ASSERT_SVH
`define CIRCLE_CIRCLE_INTERSECTION_ASSERT_SVH

`ifndef ASSERT_OFF

`define CCI_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("circle intersection assertion failed");

`define CCI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("circle intersection assertion failed");

`else

`define CCI_ASSERT(lbl, ck, rn, prop)

`define CCI_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

>>> sv/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg
// Widths, word types and cell state types for the circle intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cci_pkg;

  localparam int MW   = 33;           // center difference magnitude
  localparam int DW   = 67;           // squared center distance
  localparam int KW   = 68;           // chord term magnitude
  localparam int R2W  = 62;           // squared radius
  localparam int RADW = 132;          // square root radicand
  localparam int SW   = RADW / 2;     // square root width, one bit per cell
  localparam int REMW = SW + 3;       // square root partial remainder
  localparam int NW   = MW + KW + 2;  // division numerator
  localparam int QB   = 41;           // quotient bits kept
  localparam int TW   = DW + 1;       // divisor 2D
  localparam int DRW  = DW + 2;       // division partial remainder
  localparam int CW   = 43;           // unsaturated coordinate

  typedef struct packed {
    logic signed [31:0] center_a_x;
    logic signed [31:0] center_a_y;
    logic        [30:0] radius_a;
    logic signed [31:0] center_b_x;
    logic signed [31:0] center_b_y;
    logic        [30:0] radius_b;
    logic               want_upper;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               no_intersection;
  } out_word_t;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [SW-1:0]   root;
  } sq_state_t;

  typedef struct packed {
    logic [DRW-1:0] rem;
    logic [QB-1:0]  nq;
  } dv_state_t;

  typedef struct packed {
    logic               noint;
    logic               upper;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic               ndx;
    logic               ndy;
    logic               kneg;
    logic [MW-1:0]      mdx;
    logic [MW-1:0]      mdy;
    logic [KW-1:0]      km;
    logic [DW-1:0]      d;
  } sq_side_t;

  typedef struct packed {
    logic               noint;
    logic               upper;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [TW-1:0]      twod;
    logic [3:0]         neg;
    logic [3:0]         ovf;
  } dv_side_t;

endpackage

`default_nettype wire

>>> sv/cci_sqrt_cell.sv
// ----------------------------------------------------------------------------
// cci_sqrt_cell
// One restoring square root step: brings in two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cci_sqrt_cell (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire cci_pkg::sq_state_t sq_in,
  output cci_pkg::sq_state_t      sq_out
);

  cci_pkg::sq_state_t         stage_r;
  cci_pkg::sq_state_t         stage_nxt;
  logic [cci_pkg::REMW-1:0]   rem_s;
  logic [cci_pkg::REMW-1:0]   trial;

  always_comb begin
    rem_s = {sq_in.rem[cci_pkg::REMW-3:0], sq_in.rad[cci_pkg::RADW-1 -: 2]};
    trial = {1'b0, sq_in.root, 2'b01};
    stage_nxt.rad = {sq_in.rad[cci_pkg::RADW-3:0], 2'b00};
    if (rem_s >= trial) begin
      stage_nxt.rem  = rem_s - trial;
      stage_nxt.root = {sq_in.root[cci_pkg::SW-2:0], 1'b1};
    end else begin
      stage_nxt.rem  = rem_s;
      stage_nxt.root = {sq_in.root[cci_pkg::SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign sq_out = stage_r;

endmodule

`default_nettype wire

>>> sv/cci_div_cell.sv
// ----------------------------------------------------------------------------
// cci_div_cell
// One restoring division step: shifts in a numerator bit, yields one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cci_div_cell (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [cci_pkg::TW-1:0]  twod,
  input  wire cci_pkg::dv_state_t      dv_in,
  output cci_pkg::dv_state_t           dv_out
);

  cci_pkg::dv_state_t        stage_r;
  cci_pkg::dv_state_t        stage_nxt;
  logic [cci_pkg::DRW-1:0]   rem_s;
  logic                      qbit;

  // The numerator bits leave at the top of nq while quotient bits enter below.
  always_comb begin
    rem_s = {dv_in.rem[cci_pkg::DRW-2:0], dv_in.nq[cci_pkg::QB-1]};
    qbit  = (rem_s >= cci_pkg::DRW'(twod));
    stage_nxt.rem = qbit ? rem_s - cci_pkg::DRW'(twod) : rem_s;
    stage_nxt.nq  = {dv_in.nq[cci_pkg::QB-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign dv_out = stage_r;

endmodule

`default_nettype wire

>>> sv/circle_circle_intersection.sv
// Throughput: one word per cycle unless the output stalls; the whole pipeline advances together.
// Depth is set by the 66-cell square root row and the four 41-cell divider rows.
// A stalled valid output holds every stage, so in_stall follows out_stall while out_valid is high.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// circle_circle_intersection
// Intersection point of two circles in fixed point, as a pipeline of cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "circle_circle_intersection_assert.svh"

module circle_circle_intersection (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cci_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cci_pkg::out_word_t      out_word
);

  localparam int NSTG = 8 + cci_pkg::SW + 4 + cci_pkg::QB;
  localparam int RDW  = cci_pkg::R2W + cci_pkg::DW;

  function automatic logic [cci_pkg::NW:0] ssum(
    input logic [cci_pkg::NW-1:0] a, input logic an,
    input logic [cci_pkg::NW-1:0] b, input logic bn);
    if (an == bn) begin
      return {an, a + b};
    end else if (a >= b) begin
      return {an, a - b};
    end else begin
      return {bn, b - a};
    end
  endfunction

  logic                 en;
  logic [NSTG-1:0]      vld_r;
  logic [NSTG-1:0]      vld_nxt;
  logic                 out_valid_r;
  cci_pkg::out_word_t   out_word_r;
  cci_pkg::out_word_t   out_word_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // Front stages: differences, squares, distance, chord terms, products and radicand.
  cci_pkg::in_word_t            in_r;
  logic signed [cci_pkg::MW-1:0] dx_c, dy_c;
  logic [cci_pkg::MW-1:0]       mdx_r, mdy_r, mdx_nxt, mdy_nxt;
  logic                         ndx_r, ndy_r;
  logic [30:0]                  ra_r, rb_r;
  logic signed [31:0]           ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r;
  logic                         up2_r, up3_r, up4_r;
  logic [cci_pkg::MW-1:0]       mdx3_r, mdy3_r, mdx4_r, mdy4_r;
  logic                         ndx3_r, ndy3_r, ndx4_r, ndy4_r;
  logic [2*cci_pkg::MW-1:0]     sqx_r, sqy_r;
  logic [cci_pkg::R2W-1:0]      ra2_r, rb2_r, ra2_4_r, rb2_4_r, ra2_5_r;
  logic [cci_pkg::DW-1:0]       d4_r;
  logic [cci_pkg::KW-1:0]       p4_r;
  logic                         f4_dzero_r;
  cci_pkg::sq_side_t            f5_r, f6_r, f7_r, f8_r, f8_nxt;
  logic [64:0]                  rdp_r [0:3];
  logic [67:0]                  kkp_r [0:2];
  logic [2*cci_pkg::KW-1:0]     t7_r, kk7_r, t_c, kk_c;
  logic [RDW-1:0]               rd_c;
  logic [cci_pkg::RADW-1:0]     rad8_r;

  // The wide products are split into pieces of about 32 by 32 bits and summed a stage later.
  always_comb begin
    dx_c    = cci_pkg::MW'(in_r.center_b_x) - cci_pkg::MW'(in_r.center_a_x);
    dy_c    = cci_pkg::MW'(in_r.center_b_y) - cci_pkg::MW'(in_r.center_a_y);
    mdx_nxt = dx_c[cci_pkg::MW-1] ? cci_pkg::MW'(-dx_c) : cci_pkg::MW'(dx_c);
    mdy_nxt = dy_c[cci_pkg::MW-1] ? cci_pkg::MW'(-dy_c) : cci_pkg::MW'(dy_c);
    rd_c    = RDW'(rdp_r[0]) + (RDW'(rdp_r[1]) << 34)
            + (RDW'(rdp_r[2]) << 31) + (RDW'(rdp_r[3]) << 65);
    t_c     = (2*cci_pkg::KW)'({rd_c, 2'b00});
    kk_c    = (2*cci_pkg::KW)'(kkp_r[0]) + ((2*cci_pkg::KW)'(kkp_r[1]) << 35)
            + ((2*cci_pkg::KW)'(kkp_r[2]) << 68);
    f8_nxt       = f7_r;
    f8_nxt.noint = f7_r.noint || (t7_r < kk7_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r  <= in_word;
      // difference stage
      mdx_r <= mdx_nxt;
      mdy_r <= mdy_nxt;
      ndx_r <= dx_c[cci_pkg::MW-1];
      ndy_r <= dy_c[cci_pkg::MW-1];
      ra_r  <= in_r.radius_a;
      rb_r  <= in_r.radius_b;
      ax2_r <= in_r.center_a_x;
      ay2_r <= in_r.center_a_y;
      up2_r <= in_r.want_upper;
      // square stage
      sqx_r  <= (2*cci_pkg::MW)'(mdx_r) * (2*cci_pkg::MW)'(mdx_r);
      sqy_r  <= (2*cci_pkg::MW)'(mdy_r) * (2*cci_pkg::MW)'(mdy_r);
      ra2_r  <= cci_pkg::R2W'(ra_r) * cci_pkg::R2W'(ra_r);
      rb2_r  <= cci_pkg::R2W'(rb_r) * cci_pkg::R2W'(rb_r);
      mdx3_r <= mdx_r;
      mdy3_r <= mdy_r;
      ndx3_r <= ndx_r;
      ndy3_r <= ndy_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      up3_r  <= up2_r;
      // distance stage
      d4_r       <= cci_pkg::DW'(sqx_r) + cci_pkg::DW'(sqy_r);
      p4_r       <= cci_pkg::KW'(ra2_r) + cci_pkg::KW'(sqx_r) + cci_pkg::KW'(sqy_r);
      f4_dzero_r <= (sqx_r == '0) && (sqy_r == '0);
      ra2_4_r    <= ra2_r;
      rb2_4_r    <= rb2_r;
      mdx4_r     <= mdx3_r;
      mdy4_r     <= mdy3_r;
      ndx4_r     <= ndx3_r;
      ndy4_r     <= ndy3_r;
      ax4_r      <= ax3_r;
      ay4_r      <= ay3_r;
      up4_r      <= up3_r;
      // chord term K as sign and magnitude
      f5_r.noint <= f4_dzero_r;
      f5_r.upper <= up4_r;
      f5_r.ax    <= ax4_r;
      f5_r.ay    <= ay4_r;
      f5_r.ndx   <= ndx4_r;
      f5_r.ndy   <= ndy4_r;
      f5_r.mdx   <= mdx4_r;
      f5_r.mdy   <= mdy4_r;
      f5_r.d     <= d4_r;
      f5_r.kneg  <= p4_r < cci_pkg::KW'(rb2_4_r);
      f5_r.km    <= (p4_r < cci_pkg::KW'(rb2_4_r)) ? cci_pkg::KW'(rb2_4_r) - p4_r
                                                    : p4_r - cci_pkg::KW'(rb2_4_r);
      ra2_5_r    <= ra2_4_r;
      // partial products of ra^2*D and K^2
      f6_r     <= f5_r;
      rdp_r[0] <= 65'(ra2_5_r[30:0]) * 65'(f5_r.d[33:0]);
      rdp_r[1] <= 65'(ra2_5_r[30:0]) * 65'(f5_r.d[cci_pkg::DW-1:34]);
      rdp_r[2] <= 65'(ra2_5_r[cci_pkg::R2W-1:31]) * 65'(f5_r.d[33:0]);
      rdp_r[3] <= 65'(ra2_5_r[cci_pkg::R2W-1:31]) * 65'(f5_r.d[cci_pkg::DW-1:34]);
      kkp_r[0] <= 68'(f5_r.km[33:0]) * 68'(f5_r.km[33:0]);
      kkp_r[1] <= 68'(f5_r.km[33:0]) * 68'(f5_r.km[cci_pkg::KW-1:34]);
      kkp_r[2] <= 68'(f5_r.km[cci_pkg::KW-1:34]) * 68'(f5_r.km[cci_pkg::KW-1:34]);
      // 4*ra^2*D and K^2
      f7_r  <= f6_r;
      t7_r  <= t_c;
      kk7_r <= kk_c;
      // radicand
      f8_r   <= f8_nxt;
      rad8_r <= cci_pkg::RADW'(t7_r - kk7_r);
    end
  end

  // Square root row.
  cci_pkg::sq_state_t sq_chain [0:cci_pkg::SW];
  cci_pkg::sq_side_t  sq_side  [0:cci_pkg::SW];

  assign sq_chain[0].rad  = rad8_r;
  assign sq_chain[0].rem  = '0;
  assign sq_chain[0].root = '0;
  assign sq_side[0]       = f8_r;

  for (genvar k = 0; k < cci_pkg::SW; k++) begin : g_sqrt
    cci_pkg::sq_side_t side_r;
    cci_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .sq_in  (sq_chain[k]),
      .sq_out (sq_chain[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_r <= sq_side[k];
      end
    end
    assign sq_side[k+1] = side_r;
  end

  // Products, signed numerators and divider setup.
  cci_pkg::sq_side_t       sq_end;
  cci_pkg::sq_side_t       p0_side_r, p1_side_r;
  logic [66:0]             mp_r [0:7];
  logic [cci_pkg::NW-1:0]  pa_r, pb_r, pc_r, pe_r;
  logic [cci_pkg::NW:0]    s_c [0:3];
  logic [cci_pkg::NW-1:0]  num_r [0:3];
  logic [3:0]              neg2_r;
  cci_pkg::dv_side_t       p2_side_r, p3_side_r, p3_side_nxt;
  cci_pkg::dv_state_t      dv_init_r [0:3];
  logic [3:0]              ovf_c;
  logic [cci_pkg::NW-1:0]  high_c [0:3];
  logic                    nk_x, nk_y;
  logic [cci_pkg::SW-1:0]  root_c;

  assign sq_end = sq_side[cci_pkg::SW];
  assign root_c = sq_chain[cci_pkg::SW].root;
  assign nk_x   = p1_side_r.ndx ^ p1_side_r.kneg;
  assign nk_y   = p1_side_r.ndy ^ p1_side_r.kneg;

  always_comb begin
    s_c[0] = ssum(pa_r, nk_x, pe_r, p1_side_r.ndy);
    s_c[1] = ssum(pb_r, nk_y, pc_r, !p1_side_r.ndx);
    s_c[2] = ssum(pa_r, nk_x, pe_r, !p1_side_r.ndy);
    s_c[3] = ssum(pb_r, nk_y, pc_r, p1_side_r.ndx);
    for (int l = 0; l < 4; l++) begin
      high_c[l] = num_r[l] >> cci_pkg::QB;
      ovf_c[l]  = high_c[l] >= cci_pkg::NW'(p2_side_r.twod);
    end
    p3_side_nxt     = p2_side_r;
    p3_side_nxt.neg = neg2_r;
    p3_side_nxt.ovf = ovf_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products of the four numerator terms
      p0_side_r <= sq_end;
      mp_r[0]   <= 67'(sq_end.mdx) * 67'(sq_end.km[33:0]);
      mp_r[1]   <= 67'(sq_end.mdx) * 67'(sq_end.km[cci_pkg::KW-1:34]);
      mp_r[2]   <= 67'(sq_end.mdy) * 67'(sq_end.km[33:0]);
      mp_r[3]   <= 67'(sq_end.mdy) * 67'(sq_end.km[cci_pkg::KW-1:34]);
      mp_r[4]   <= 67'(sq_end.mdx) * 67'(root_c[32:0]);
      mp_r[5]   <= 67'(sq_end.mdx) * 67'(root_c[cci_pkg::SW-1:33]);
      mp_r[6]   <= 67'(sq_end.mdy) * 67'(root_c[32:0]);
      mp_r[7]   <= 67'(sq_end.mdy) * 67'(root_c[cci_pkg::SW-1:33]);
      p1_side_r <= p0_side_r;
      pa_r <= cci_pkg::NW'(mp_r[0]) + (cci_pkg::NW'(mp_r[1]) << 34);
      pb_r <= cci_pkg::NW'(mp_r[2]) + (cci_pkg::NW'(mp_r[3]) << 34);
      pc_r <= cci_pkg::NW'(mp_r[4]) + (cci_pkg::NW'(mp_r[5]) << 33);
      pe_r <= cci_pkg::NW'(mp_r[6]) + (cci_pkg::NW'(mp_r[7]) << 33);
      // Adding D before dividing by 2D rounds halves away from zero.
      for (int l = 0; l < 4; l++) begin
        num_r[l]  <= s_c[l][cci_pkg::NW-1:0] + cci_pkg::NW'(p1_side_r.d);
        neg2_r[l] <= s_c[l][cci_pkg::NW];
      end
      p2_side_r.noint <= p1_side_r.noint;
      p2_side_r.upper <= p1_side_r.upper;
      p2_side_r.ax    <= p1_side_r.ax;
      p2_side_r.ay    <= p1_side_r.ay;
      p2_side_r.twod  <= {p1_side_r.d, 1'b0};
      p2_side_r.neg   <= '0;
      p2_side_r.ovf   <= '0;
      p3_side_r       <= p3_side_nxt;
      for (int l = 0; l < 4; l++) begin
        dv_init_r[l].rem <= ovf_c[l] ? '0 : cci_pkg::DRW'(high_c[l]);
        dv_init_r[l].nq  <= num_r[l][cci_pkg::QB-1:0];
      end
    end
  end

  // Divider rows, one per coordinate: x1, y1, x2, y2.
  cci_pkg::dv_side_t dv_side [0:cci_pkg::QB];
  assign dv_side[0] = p3_side_r;

  for (genvar j = 0; j < cci_pkg::QB; j++) begin : g_dside
    cci_pkg::dv_side_t side_r;
    always_ff @(posedge clk) begin
      if (en) begin
        side_r <= dv_side[j];
      end
    end
    assign dv_side[j+1] = side_r;
  end

  logic [cci_pkg::QB-1:0] quot_c [0:3];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    cci_pkg::dv_state_t dv_chain [0:cci_pkg::QB];
    assign dv_chain[0] = dv_init_r[l];
    for (genvar j = 0; j < cci_pkg::QB; j++) begin : g_div
      cci_div_cell u_cell (
        .clk    (clk),
        .en     (en),
        .twod   (dv_side[j].twod),
        .dv_in  (dv_chain[j]),
        .dv_out (dv_chain[j+1])
      );
    end
    assign quot_c[l] = dv_chain[cci_pkg::QB].nq;
  end

  // Clamp, offset by the first center, choose and saturate.
  localparam logic [cci_pkg::QB-1:0] QCLAMP = cci_pkg::QB'(1) << (cci_pkg::QB - 1);
  localparam logic signed [cci_pkg::CW-1:0] SMAX = cci_pkg::CW'(32'sh7fffffff);
  localparam logic signed [cci_pkg::CW-1:0] SMIN = -cci_pkg::CW'(32'sh7fffffff) - 1;

  cci_pkg::dv_side_t               fs;
  logic [cci_pkg::QB-1:0]          mag_c [0:3];
  logic signed [cci_pkg::CW-1:0]   crd_c [0:3];
  logic signed [cci_pkg::CW-1:0]   off_c;
  logic signed [cci_pkg::CW-1:0]   sel_x, sel_y;
  logic                            pick1;

  assign fs = dv_side[cci_pkg::QB];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag_c[l] = (fs.ovf[l] || quot_c[l] > QCLAMP) ? QCLAMP : quot_c[l];
      off_c    = $signed(cci_pkg::CW'(mag_c[l]));
      if (fs.neg[l]) begin
        off_c = -off_c;
      end
      crd_c[l] = ((l % 2) == 0) ? cci_pkg::CW'(fs.ax) + off_c : cci_pkg::CW'(fs.ay) + off_c;
    end
    pick1 = fs.upper && (crd_c[1] > crd_c[3]);
    sel_x = pick1 ? crd_c[0] : crd_c[2];
    sel_y = pick1 ? crd_c[1] : crd_c[3];
    if (sel_x > SMAX) begin
      sel_x = SMAX;
    end else if (sel_x < SMIN) begin
      sel_x = SMIN;
    end
    if (sel_y > SMAX) begin
      sel_y = SMAX;
    end else if (sel_y < SMIN) begin
      sel_y = SMIN;
    end
    out_word_nxt.no_intersection = fs.noint;
    out_word_nxt.point_x = fs.noint ? 32'sd0 : sel_x[31:0];
    out_word_nxt.point_y = fs.noint ? 32'sd0 : sel_y[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `CCI_ASSERT(a_noint_zero, clk, rst_n, out_valid_r && out_word_r.no_intersection |-> out_word_r.point_x == 32'sd0 && out_word_r.point_y == 32'sd0)
  `CCI_ASSERT_NEXT(a_freeze, clk, rst_n, !en, $stable(vld_r) && out_valid_r)
  `CCI_ASSERT_NEXT(a_dzero_noint, clk, rst_n, en && vld_r[3] && f4_dzero_r, f5_r.noint)

endmodule

`default_nettype wire
